// File: design/tqas_pkg.sv
// shared types and codes for the two-queue alternating scheduler
package tqas_pkg;

	// request kinds carried on the mode field
	typedef enum logic [1:0] {
		MODE_ADD      = 2'd0,
		MODE_WAIT     = 2'd1,
		MODE_REINSERT = 2'd2,
		MODE_YIELD    = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_READY_FULL   = 2'd1,
		ST_BLOCKED_FULL = 2'd2,
		ST_NO_THREAD    = 2'd3
	} status_t;

	// per-cycle operation applied to a whole row of cells
	typedef enum logic [1:0] {
		Q_HOLD       = 2'd0,
		Q_PUSH_BACK  = 2'd1,
		Q_PUSH_FRONT = 2'd2,
		Q_POP        = 2'd3
	} qop_t;

	// occupancy flags a queue reports to the scheduler
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	// width of the identifier ports
	localparam int unsigned ID_PORT_BITS = 8;

endpackage

// File: design/tqas_cell.sv
// one slot of a shifting queue: holds an identifier and its occupancy bit
module tqas_cell #(
	parameter int unsigned W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tqas_pkg::qop_t   op,
	input  logic [W-1:0]     new_id,
	input  logic             left_valid,
	input  logic [W-1:0]     left_data,
	input  logic             right_valid,
	input  logic [W-1:0]     right_data,
	output logic             valid,
	output logic [W-1:0]     data
);

	logic         valid_q;
	logic [W-1:0] data_q;
	logic         valid_d;
	logic [W-1:0] data_d;
	logic         load_back;

	// the first empty slot behind an occupied one takes an appended entry
	assign load_back = !valid_q && left_valid;

	// next slot contents from the row operation and the neighbours
	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		unique case (op)
			tqas_pkg::Q_PUSH_BACK: begin
				if (load_back) begin
					valid_d = 1'b1;
					data_d  = new_id;
				end
			end
			tqas_pkg::Q_PUSH_FRONT: begin
				valid_d = left_valid;
				data_d  = left_data;
			end
			tqas_pkg::Q_POP: begin
				valid_d = right_valid;
				data_d  = right_data;
			end
			default: begin
				valid_d = valid_q;
				data_d  = data_q;
			end
		endcase
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// identifier
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// File: design/tqas_queue.sv
// row of cells forming a double-ended queue of DEPTH-1 identifiers
module tqas_queue #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned W     = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tqas_pkg::qop_t   op,
	input  logic [W-1:0]     new_id,
	output logic [W-1:0]     head,
	output tqas_pkg::qstat_t stat
);

	localparam int unsigned CELLS = DEPTH - 1;

	logic         cell_valid [CELLS];
	logic [W-1:0] cell_data  [CELLS];

	// each cell sees its neighbours; the front cell sees the new entry on its left
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic         lv;
		logic [W-1:0] ld;
		logic         rv;
		logic [W-1:0] rd;

		if (i == 0) begin : g_front
			assign lv = 1'b1;
			assign ld = new_id;
		end else begin : g_mid_left
			assign lv = cell_valid[i-1];
			assign ld = cell_data[i-1];
		end

		if (i == CELLS - 1) begin : g_back
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_mid_right
			assign rv = cell_valid[i+1];
			assign rd = cell_data[i+1];
		end

		tqas_cell #(
			.W (W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.new_id      (new_id),
			.left_valid  (lv),
			.left_data   (ld),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (cell_valid[i]),
			.data        (cell_data[i])
		);
	end

	// head sits in the front cell, occupancy is contiguous from the front
	assign head       = cell_data[0];
	assign stat.empty = !cell_valid[0];
	assign stat.full  = cell_valid[CELLS-1];

endmodule

// File: design/two_queue_alternating_scheduler.sv
// top level: ready and blocked queues with alternating dispatch on yield
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------------------------
//   request | req_valid | req_stall | mode, thread_id
//   result  | rsp_valid | rsp_stall | dispatched, dispatch_id, from_blocked, status
//
// One request is taken per cycle unless stalled; its result is registered and appears
// the next cycle. Every queue operation is one shift or load across the row of cells.
// A held result stalls new requests only while the result side itself stalls.
// Reset empties both queues, drops the result valid and selects the ready queue first;
// the result payload registers are not reset.
module two_queue_alternating_scheduler #(
	parameter int unsigned DEPTH   = 16,
	parameter int unsigned ID_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] mode,
	input  logic [7:0] thread_id,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic       dispatched,
	output logic [7:0] dispatch_id,
	output logic       from_blocked,
	output logic [1:0] status
);

	localparam int unsigned W =
		(ID_BITS < tqas_pkg::ID_PORT_BITS) ? ID_BITS : tqas_pkg::ID_PORT_BITS;

	logic                 req_fire;
	logic [W-1:0]         id_in;
	tqas_pkg::mode_t      mode_in;
	tqas_pkg::qop_t       rdy_op;
	tqas_pkg::qop_t       blk_op;
	logic [W-1:0]         rdy_head;
	logic [W-1:0]         blk_head;
	tqas_pkg::qstat_t     rdy_stat;
	tqas_pkg::qstat_t     blk_stat;
	logic                 pick_ready_q;
	logic                 pick_ready_d;
	logic                 res_disp;
	logic                 res_from;
	logic [W-1:0]         res_thread;
	tqas_pkg::status_t    res_status;
	logic                 rsp_valid_q;
	logic                 dispatched_q;
	logic [W-1:0]         thread_q;
	logic                 from_blocked_q;
	tqas_pkg::status_t    status_q;

	// request handshake: hold off only while a result waits on a stalled consumer
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_fire  = req_valid && !req_stall;
	assign id_in     = thread_id[W-1:0];
	assign mode_in   = tqas_pkg::mode_t'(mode);

	tqas_queue #(
		.DEPTH (DEPTH),
		.W     (W)
	) u_ready (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (rdy_op),
		.new_id (id_in),
		.head   (rdy_head),
		.stat   (rdy_stat)
	);

	tqas_queue #(
		.DEPTH (DEPTH),
		.W     (W)
	) u_blocked (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (blk_op),
		.new_id (id_in),
		.head   (blk_head),
		.stat   (blk_stat)
	);

	// decode the request into queue operations and a result
	always_comb begin
		rdy_op       = tqas_pkg::Q_HOLD;
		blk_op       = tqas_pkg::Q_HOLD;
		res_disp     = 1'b0;
		res_from     = 1'b0;
		res_thread   = '0;
		res_status   = tqas_pkg::ST_OK;
		pick_ready_d = pick_ready_q;
		if (req_fire) begin
			unique case (mode_in)
				tqas_pkg::MODE_ADD: begin
					if (rdy_stat.full) begin
						res_status = tqas_pkg::ST_READY_FULL;
					end else begin
						rdy_op = tqas_pkg::Q_PUSH_BACK;
					end
				end
				tqas_pkg::MODE_WAIT: begin
					if (blk_stat.full) begin
						res_status = tqas_pkg::ST_BLOCKED_FULL;
					end else begin
						blk_op = tqas_pkg::Q_PUSH_BACK;
					end
				end
				tqas_pkg::MODE_REINSERT: begin
					if (blk_stat.full) begin
						res_status = tqas_pkg::ST_BLOCKED_FULL;
					end else begin
						blk_op = tqas_pkg::Q_PUSH_FRONT;
					end
				end
				tqas_pkg::MODE_YIELD: begin
					pick_ready_d = !pick_ready_q;
					// blocked queue on its turn, ready queue as fallback
					priority if (!pick_ready_q && !blk_stat.empty) begin
						blk_op     = tqas_pkg::Q_POP;
						res_disp   = 1'b1;
						res_from   = 1'b1;
						res_thread = blk_head;
					end else if (!rdy_stat.empty) begin
						rdy_op     = tqas_pkg::Q_POP;
						res_disp   = 1'b1;
						res_thread = rdy_head;
					end else begin
						res_status = tqas_pkg::ST_NO_THREAD;
					end
				end
				default: begin
					res_status = tqas_pkg::ST_OK;
				end
			endcase
		end
	end

	// alternating source flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_ready_q <= 1'b1;
			rsp_valid_q  <= 1'b0;
		end else begin
			pick_ready_q <= pick_ready_d;
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			dispatched_q   <= res_disp;
			thread_q       <= res_thread;
			from_blocked_q <= res_from;
			status_q       <= res_status;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign dispatched   = dispatched_q;
	assign dispatch_id  = tqas_pkg::ID_PORT_BITS'(thread_q);
	assign from_blocked = from_blocked_q;
	assign status       = status_q;

	// a dispatch always reports success
	a_disp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && dispatched_q |-> status_q == tqas_pkg::ST_OK)
		else $error("dispatch with error status");

	// nothing dispatched means no identifier and no source
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !dispatched_q |-> thread_q == '0 && !from_blocked_q)
		else $error("stray identifier on non-dispatch result");

	// every accepted yield flips the source flag
	a_flag_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && mode_in == tqas_pkg::MODE_YIELD |=> pick_ready_q != $past(pick_ready_q))
		else $error("source flag did not toggle");

	// a blocked-queue dispatch happens only on the blocked turn
	a_blk_turn: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && blk_op == tqas_pkg::Q_POP |-> !pick_ready_q)
		else $error("blocked queue popped on ready turn");

	// a queue is never both empty and full
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		!(rdy_stat.empty && rdy_stat.full) && !(blk_stat.empty && blk_stat.full))
		else $error("queue occupancy inconsistent");

endmodule

// File: tb/sv/tqas_checker.sv
// checker for the two-queue alternating scheduler: watches both channels, predicts and compares
module tqas_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  logic [1:0] mode,
	input  logic [7:0] thread_id,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  logic       dispatched,
	input  logic [7:0] dispatch_id,
	input  logic       from_blocked,
	input  logic [1:0] status,
	output int         fail_count,
	output int         pending
);

	// one scheduling result as the block should present it
	typedef struct packed {
		logic              dispatched;
		logic [7:0]        dispatch_id;
		logic              from_blocked;
		tqas_pkg::status_t status;
	} sched_result_t;

	// own copy of both rings: 16 slots each, one always left free
	logic [7:0] ready_ids [16];
	logic [7:0] blocked_ids [16];
	logic [3:0] ready_rd, ready_wr;
	logic [3:0] blocked_rd, blocked_wr;
	logic       ready_turn;

	sched_result_t scheduled_results[$];
	int            results_seen;

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= 200)
			$display("checker: result %0d %s: got %0d, expected %0d",
				results_seen, what, got, want);
	endtask

	// work out the result of one request and update the rings
	task automatic schedule_request(input tqas_pkg::mode_t m, input logic [7:0] id,
			output sched_result_t r);
		logic got;
		got = 1'b0;
		r = '{dispatched: 1'b0, dispatch_id: 8'd0, from_blocked: 1'b0,
			status: tqas_pkg::ST_OK};
		case (m)
			tqas_pkg::MODE_ADD: begin
				if (4'(ready_wr + 4'd1) == ready_rd) begin
					r.status = tqas_pkg::ST_READY_FULL;
				end else begin
					ready_ids[ready_wr] = id;
					ready_wr = ready_wr + 4'd1;
				end
			end
			tqas_pkg::MODE_WAIT: begin
				if (4'(blocked_wr + 4'd1) == blocked_rd) begin
					r.status = tqas_pkg::ST_BLOCKED_FULL;
				end else begin
					blocked_ids[blocked_wr] = id;
					blocked_wr = blocked_wr + 4'd1;
				end
			end
			tqas_pkg::MODE_REINSERT: begin
				if (4'(blocked_wr + 4'd1) == blocked_rd) begin
					r.status = tqas_pkg::ST_BLOCKED_FULL;
				end else begin
					blocked_rd = blocked_rd - 4'd1;
					blocked_ids[blocked_rd] = id;
				end
			end
			default: begin
				// yield: the turn flag flips whether or not anything is dispatched
				if (ready_turn) begin
					ready_turn = 1'b0;
				end else begin
					ready_turn = 1'b1;
					if (blocked_rd != blocked_wr) begin
						r.dispatch_id = blocked_ids[blocked_rd];
						r.from_blocked = 1'b1;
						blocked_rd = blocked_rd + 4'd1;
						got = 1'b1;
					end
				end
				// ready queue is the source on its turn and the fallback otherwise
				if (!got && ready_rd != ready_wr) begin
					r.dispatch_id = ready_ids[ready_rd];
					ready_rd = ready_rd + 4'd1;
					got = 1'b1;
				end
				if (got)
					r.dispatched = 1'b1;
				else
					r.status = tqas_pkg::ST_NO_THREAD;
			end
		endcase
	endtask

	// compare accepted results, then predict for the accepted request
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		sched_result_t next;
		if (!arst_n) begin
			ready_rd = '0;
			ready_wr = '0;
			blocked_rd = '0;
			blocked_wr = '0;
			ready_turn = 1'b1;
			scheduled_results.delete();
			results_seen = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (scheduled_results.size() == 0) begin
					report_mismatch("arrived with nothing outstanding", 1, 0);
				end else begin
					want = scheduled_results.pop_front();
					if (dispatched !== want.dispatched)
						report_mismatch("dispatched", dispatched, want.dispatched);
					if (dispatch_id !== want.dispatch_id)
						report_mismatch("dispatch_id", dispatch_id, want.dispatch_id);
					if (from_blocked !== want.from_blocked)
						report_mismatch("from_blocked", from_blocked, want.from_blocked);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
				end
				results_seen++;
			end
			if (req_valid === 1'b1 && req_stall === 1'b0) begin
				schedule_request(tqas_pkg::mode_t'(mode), thread_id, next);
				scheduled_results.push_back(next);
			end
			pending = scheduled_results.size();
		end
	end

endmodule

// File: tb/sv/tb_two_queue_alternating_scheduler.sv
// testbench top for the two-queue alternating scheduler: stimulus, idling and verdict
module tb_two_queue_alternating_scheduler;

	localparam int CYCLE_LIMIT = 400000;

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_stall;
	tqas_pkg::mode_t mode;
	logic [7:0]      thread_id;
	logic            rsp_valid;
	logic            rsp_stall;
	logic            dispatched;
	logic [7:0]      dispatch_id;
	logic            from_blocked;
	logic [1:0]      status;

	int fail_count;
	int pending;
	int cycle_count;
	int requests_sent;
	int send_idle_pct;
	int rsp_idle_pct;

	two_queue_alternating_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.mode         (mode),
		.thread_id    (thread_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.dispatched   (dispatched),
		.dispatch_id  (dispatch_id),
		.from_blocked (from_blocked),
		.status       (status)
	);

	tqas_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.mode         (mode),
		.thread_id    (thread_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.dispatched   (dispatched),
		.dispatch_id  (dispatch_id),
		.from_blocked (from_blocked),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 8-unit clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side stalls at random
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
	end

	// present one request after a random gap and hold it until taken
	task automatic send_request(input tqas_pkg::mode_t m, input logic [7:0] id);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		thread_id <= id;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	// identifiers lean on the extremes now and then
	function automatic logic [7:0] pick_id();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one burst of random requests: filling runs, draining runs or a plain mix
	task automatic random_burst();
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		len = $urandom_range(4, 20);
		for (int i = 0; i < len; i++) begin
			case (kind)
				0, 1:    send_request(tqas_pkg::MODE_ADD, pick_id());
				2, 3:    send_request($urandom_range(0, 1) ? tqas_pkg::MODE_WAIT
						: tqas_pkg::MODE_REINSERT, pick_id());
				4, 5, 6: send_request(tqas_pkg::MODE_YIELD, pick_id());
				default: send_request(tqas_pkg::mode_t'($urandom_range(0, 3)), pick_id());
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		mode = tqas_pkg::MODE_ADD;
		thread_id = 8'd0;
		rsp_stall = 1'b0;
		cycle_count = 0;
		requests_sent = 0;
		send_idle_pct = 14;
		rsp_idle_pct = 61;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: yield on empty queues, extremes of the id, blocked front and tail,
		// alternation between queues and fallback from an empty blocked queue
		send_request(tqas_pkg::MODE_YIELD, 8'hFF);
		send_request(tqas_pkg::MODE_ADD, 8'h00);
		send_request(tqas_pkg::MODE_ADD, 8'hFF);
		send_request(tqas_pkg::MODE_WAIT, 8'hA5);
		send_request(tqas_pkg::MODE_REINSERT, 8'h5A);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_ADD, 8'h3C);
		send_request(tqas_pkg::MODE_ADD, 8'hC3);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_REINSERT, 8'h81);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);
		send_request(tqas_pkg::MODE_YIELD, 8'h00);

		// sender idles lightly, result side stalls heavily
		while (requests_sent < 500) random_burst();

		// hold off until every outstanding result has come back
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);

		// roles swapped
		send_idle_pct = 61;
		rsp_idle_pct = 14;
		while (requests_sent < 980) random_burst();

		// full rate on both sides
		send_idle_pct = 0;
		rsp_idle_pct = 0;
		while (requests_sent < 1460) random_burst();

		// drain and settle
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
